// ===== hdl/vr2d_pkg.sv =====
`timescale 1ns / 1ps

package vr2d_pkg;

   // largest magnitude a normal component keeps after clamping
   localparam int NORMAL_MAX = 64;

   localparam int VEL_W  = 16;  // Q8.8 velocity
   localparam int NORM_W = 8;   // normal component, signed
   localparam int NN_W   = 14;  // n.n, unsigned, at most 2*64*64
   localparam int P_W    = 24;  // n.v, signed
   localparam int T_W    = 30;  // p*n and v*nn, signed
   localparam int NUM_W  = 31;  // v*nn - 2*p*n, signed
   localparam int MAG_W  = 30;  // |numerator|
   localparam int DVD_W  = 32;  // 2*|num| + nn
   localparam int DVS_W  = 15;  // 2*nn
   localparam int Q_W    = 18;  // quotient bits, |q| < 2^17

   localparam int STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

   typedef struct packed {
      logic             neg;
      logic [DVS_W-1:0] rem;
      logic [Q_W-1:0]   work;   // dividend bits on top, quotient bits shift in below
   } lane_type;

   typedef struct packed {
      logic                    refl;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic [DVS_W-1:0]        divisor;
      lane_type                lane_x;
      lane_type                lane_y;
   } div_stage_type;

   // one restoring step: one quotient bit
   function automatic lane_type div_step(input lane_type l, input logic [DVS_W-1:0] dvs);
      logic [DVS_W:0] cand;
      logic [DVS_W:0] diff;
      lane_type       r;
      cand = {l.rem, l.work[Q_W-1]};
      diff = cand - {1'b0, dvs};
      r    = l;
      if (cand >= {1'b0, dvs}) begin
         r.rem  = diff[DVS_W-1:0];
         r.work = {l.work[Q_W-2:0], 1'b1};
      end else begin
         r.rem  = cand[DVS_W-1:0];
         r.work = {l.work[Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== hdl/vr2d_div_stage.sv =====
`timescale 1ns / 1ps

// Three restoring-division steps on both lanes, registered.
module vr2d_div_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_in,
   input  vr2d_pkg::div_stage_type stage_in,
   output logic                    valid_out,
   output vr2d_pkg::div_stage_type stage_out
);
   import vr2d_pkg::*;

   logic          valid_ff;
   div_stage_type stage_ff;
   div_stage_type stage_in_next;

   always_comb begin
      stage_in_next = stage_in;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         stage_in_next.lane_x = div_step(stage_in_next.lane_x, stage_in.divisor);
         stage_in_next.lane_y = div_step(stage_in_next.lane_y, stage_in.divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

// ===== hdl/vector_reflection_2d_top.sv =====
`timescale 1ns / 1ps

// 2D velocity reflection. Each req transfer carries a Q8.8 velocity and an
// integer wall normal (pointing into the wall); each rsp transfer returns
// v - 2*(n.v)*n/(n.n), rounded to nearest with ties away from zero and
// saturated to 16 bits, plus a flag in rsp_tuser. Normal components are
// clamped to +/-64 first. A zero normal or n.v < 0 passes the velocity
// through with the flag low; n.v == 0 sets the flag and leaves v as is.
// The block is a 12-stage pipeline with no kept state: one transfer is
// accepted every clock unless rsp backpressure holds it, and each result
// passes through every stage register before it shows on rsp. The depth
// is set by the exact division by n.n, done as an 18-bit restoring
// divider spread over six stages of three bits each.
// Backpressure on rsp stalls the whole pipeline in place, so req_tready
// follows rsp_tready combinationally whenever the output register is full.
module vector_reflection_2d_top (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: vel_x_in[15:0], vel_y_in[31:16], normal_x[39:32], normal_y[47:40]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: vel_x_out[15:0], vel_y_out[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: reflected[0]
   output logic        rsp_tuser
);
   import vr2d_pkg::*;

   // Whole pipeline moves together; it holds only when the output is full
   // and not being taken.
   logic advance;
   logic rsp_valid_ff;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- stage 0: capture the transfer ----------------
   logic                     s0_valid_ff;
   logic signed [VEL_W-1:0]  s0_vx_ff, s0_vy_ff;
   logic signed [NORM_W-1:0] s0_nx_ff, s0_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_vx_ff <= req_tdata[15:0];
         s0_vy_ff <= req_tdata[31:16];
         s0_nx_ff <= req_tdata[39:32];
         s0_ny_ff <= req_tdata[47:40];
      end
   end

   // ---------------- stage 1: clamp normal, first products ----------------
   logic signed [NORM_W-1:0] s1_nx_in, s1_ny_in;
   logic signed [P_W-1:0]    s1_px_in, s1_py_in;
   logic [NN_W-1:0]          s1_sqx_in, s1_sqy_in;
   logic signed [NN_W:0]     sqx_full, sqy_full;

   logic                     s1_valid_ff;
   logic signed [VEL_W-1:0]  s1_vx_ff, s1_vy_ff;
   logic signed [NORM_W-1:0] s1_nx_ff, s1_ny_ff;
   logic signed [P_W-1:0]    s1_px_ff, s1_py_ff;
   logic [NN_W-1:0]          s1_sqx_ff, s1_sqy_ff;

   always_comb begin
      if (s0_nx_ff > NORM_W'(NORMAL_MAX)) begin
         s1_nx_in = NORM_W'(NORMAL_MAX);
      end else if (s0_nx_ff < -NORM_W'(NORMAL_MAX)) begin
         s1_nx_in = -NORM_W'(NORMAL_MAX);
      end else begin
         s1_nx_in = s0_nx_ff;
      end
      if (s0_ny_ff > NORM_W'(NORMAL_MAX)) begin
         s1_ny_in = NORM_W'(NORMAL_MAX);
      end else if (s0_ny_ff < -NORM_W'(NORMAL_MAX)) begin
         s1_ny_in = -NORM_W'(NORMAL_MAX);
      end else begin
         s1_ny_in = s0_ny_ff;
      end
      s1_px_in  = P_W'(s1_nx_in) * P_W'(s0_vx_ff);
      s1_py_in  = P_W'(s1_ny_in) * P_W'(s0_vy_ff);
      sqx_full  = (NN_W+1)'(s1_nx_in) * (NN_W+1)'(s1_nx_in);
      sqy_full  = (NN_W+1)'(s1_ny_in) * (NN_W+1)'(s1_ny_in);
      s1_sqx_in = sqx_full[NN_W-1:0];
      s1_sqy_in = sqy_full[NN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_vx_ff  <= s0_vx_ff;
         s1_vy_ff  <= s0_vy_ff;
         s1_nx_ff  <= s1_nx_in;
         s1_ny_ff  <= s1_ny_in;
         s1_px_ff  <= s1_px_in;
         s1_py_ff  <= s1_py_in;
         s1_sqx_ff <= s1_sqx_in;
         s1_sqy_ff <= s1_sqy_in;
      end
   end

   // ---------------- stage 2: p = n.v, nn = n.n ----------------
   logic signed [P_W-1:0]    s2_p_in;
   logic [NN_W-1:0]          s2_nn_in;

   logic                     s2_valid_ff;
   logic                     s2_refl_ff;
   logic signed [VEL_W-1:0]  s2_vx_ff, s2_vy_ff;
   logic signed [NORM_W-1:0] s2_nx_ff, s2_ny_ff;
   logic signed [P_W-1:0]    s2_p_ff;
   logic [NN_W-1:0]          s2_nn_ff;

   assign s2_p_in  = s1_px_ff + s1_py_ff;
   assign s2_nn_in = s1_sqx_ff + s1_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_refl_ff <= (s2_nn_in != '0) && !s2_p_in[P_W-1];
         s2_vx_ff   <= s1_vx_ff;
         s2_vy_ff   <= s1_vy_ff;
         s2_nx_ff   <= s1_nx_ff;
         s2_ny_ff   <= s1_ny_ff;
         s2_p_ff    <= s2_p_in;
         s2_nn_ff   <= s2_nn_in;
      end
   end

   // ---------------- stage 3: p*n and v*nn ----------------
   logic signed [NN_W:0]    nn_signed;
   logic                    s3_valid_ff;
   logic                    s3_refl_ff;
   logic signed [VEL_W-1:0] s3_vx_ff, s3_vy_ff;
   logic [NN_W-1:0]         s3_nn_ff;
   logic signed [T_W-1:0]   s3_tx_ff, s3_ty_ff;
   logic signed [T_W-1:0]   s3_vnx_ff, s3_vny_ff;

   assign nn_signed = $signed({1'b0, s2_nn_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_refl_ff <= s2_refl_ff;
         s3_vx_ff   <= s2_vx_ff;
         s3_vy_ff   <= s2_vy_ff;
         s3_nn_ff   <= s2_nn_ff;
         s3_tx_ff   <= T_W'(s2_p_ff) * T_W'(s2_nx_ff);
         s3_ty_ff   <= T_W'(s2_p_ff) * T_W'(s2_ny_ff);
         s3_vnx_ff  <= T_W'(s2_vx_ff) * T_W'(nn_signed);
         s3_vny_ff  <= T_W'(s2_vy_ff) * T_W'(nn_signed);
      end
   end

   // ---------------- stage 4: numerator, rounding bias, divider setup ----
   // round(num/nn) ties away = sign * floor((2|num| + nn) / (2 nn))
   logic signed [NUM_W-1:0] num_x, num_y;
   logic signed [NUM_W-1:0] neg_x, neg_y;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic [DVD_W-1:0]        dvd_x, dvd_y;
   div_stage_type           s4_in;

   always_comb begin
      num_x = NUM_W'(s3_vnx_ff) - $signed({s3_tx_ff, 1'b0});
      num_y = NUM_W'(s3_vny_ff) - $signed({s3_ty_ff, 1'b0});
      neg_x = -num_x;
      neg_y = -num_y;
      mag_x = num_x[NUM_W-1] ? neg_x[MAG_W-1:0] : num_x[MAG_W-1:0];
      mag_y = num_y[NUM_W-1] ? neg_y[MAG_W-1:0] : num_y[MAG_W-1:0];
      dvd_x = DVD_W'({mag_x, 1'b0}) + DVD_W'(s3_nn_ff);
      dvd_y = DVD_W'({mag_y, 1'b0}) + DVD_W'(s3_nn_ff);

      s4_in.refl        = s3_refl_ff;
      s4_in.vel_x       = s3_vx_ff;
      s4_in.vel_y       = s3_vy_ff;
      s4_in.divisor     = {s3_nn_ff, 1'b0};
      s4_in.lane_x.neg  = num_x[NUM_W-1];
      s4_in.lane_x.rem  = DVS_W'(dvd_x[DVD_W-1:Q_W]);
      s4_in.lane_x.work = dvd_x[Q_W-1:0];
      s4_in.lane_y.neg  = num_y[NUM_W-1];
      s4_in.lane_y.rem  = DVS_W'(dvd_y[DVD_W-1:Q_W]);
      s4_in.lane_y.work = dvd_y[Q_W-1:0];
   end

   logic          s4_valid_ff;
   div_stage_type s4_stage_ff;
   logic          div_valid [DIV_STAGES+1];
   div_stage_type div_stage [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_stage_ff <= s4_in;
      end
   end

   assign div_valid[0] = s4_valid_ff;
   assign div_stage[0] = s4_stage_ff;

   // ---------------- stages 5..10: restoring divider ----------------
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      vr2d_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (div_valid[g]),
         .stage_in  (div_stage[g]),
         .valid_out (div_valid[g+1]),
         .stage_out (div_stage[g+1])
      );
   end

   // ---------------- stage 11: sign, saturate, select ----------------
   div_stage_type         fin;
   logic signed [Q_W:0]   res_x, res_y;
   logic signed [VEL_W-1:0] sat_x, sat_y;
   logic signed [VEL_W-1:0] out_x_in, out_y_in;

   localparam logic signed [Q_W:0] SAT_HI = (Q_W+1)'(32767);
   localparam logic signed [Q_W:0] SAT_LO = -(Q_W+1)'(32768);

   always_comb begin
      fin   = div_stage[DIV_STAGES];
      res_x = fin.lane_x.neg ? -$signed({1'b0, fin.lane_x.work})
                             :  $signed({1'b0, fin.lane_x.work});
      res_y = fin.lane_y.neg ? -$signed({1'b0, fin.lane_y.work})
                             :  $signed({1'b0, fin.lane_y.work});
      if (res_x > SAT_HI) begin
         sat_x = 16'sh7fff;
      end else if (res_x < SAT_LO) begin
         sat_x = -16'sh8000;
      end else begin
         sat_x = res_x[VEL_W-1:0];
      end
      if (res_y > SAT_HI) begin
         sat_y = 16'sh7fff;
      end else if (res_y < SAT_LO) begin
         sat_y = -16'sh8000;
      end else begin
         sat_y = res_y[VEL_W-1:0];
      end
      // pass-through when no reflection applies
      out_x_in = fin.refl ? sat_x : fin.vel_x;
      out_y_in = fin.refl ? sat_y : fin.vel_y;
   end

   logic signed [VEL_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    rsp_refl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff    <= out_x_in;
         rsp_y_ff    <= out_y_in;
         rsp_refl_ff <= fin.refl;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_refl_ff;

endmodule

// ===== hdl/vr2d_checker.sv =====
`timescale 1ns / 1ps

module vr2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // output register empties on reset
   a_reset_clears: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // pipeline takes input exactly when the output side can move
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with rsp side");

   a_stall_holds_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_stall_holds_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

endmodule

bind vector_reflection_2d_top vr2d_checker u_vr2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
